// File: hdl/clifford_tableau_gate_update_unit_assert.svh
// Assertion macros for the Clifford tableau gate update unit.
// They expect clk_i and rst_ni in the scope that uses them.
`ifndef CLIFFORD_TABLEAU_GATE_UPDATE_UNIT_ASSERT_SVH
`define CLIFFORD_TABLEAU_GATE_UPDATE_UNIT_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define CTGU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define CTGU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ctgu_pkg.sv
// Package for the Clifford tableau gate update unit: operation codes,
// status codes and fixed field widths. No dependencies.
package ctgu_pkg;

  localparam int unsigned OpW       = 3;
  localparam int unsigned QubitW    = 5;
  localparam int unsigned CfgW      = 6;
  localparam int unsigned RowFieldW = 32;

  localparam logic [CfgW-1:0] ActiveQubitsReset = 6'd32;

  // Register indexes on the configuration port.
  localparam logic RegActiveQubits = 1'b0;

  typedef enum logic [OpW-1:0] {
    OP_X      = 3'd0,
    OP_Z      = 3'd1,
    OP_S      = 3'd2,
    OP_H      = 3'd3,
    OP_CNOT   = 3'd4,
    OP_REINIT = 3'd5,
    OP_READ   = 3'd6
  } op_e;

  localparam logic StatusDone   = 1'b0;
  localparam logic StatusReject = 1'b1;

endpackage

// File: hdl/clifford_tableau_gate_update_unit.sv
// One transaction is in work at a time, so a new op is taken only once the previous one has
// left the sequencer; a gate sweeps every row through the single row update unit behind the
// one-read, one-write tableau memory. Reset is asynchronous and active low; it loads the
// identity tableau for 32 active qubits at once through the per-row valid bits.
`include "clifford_tableau_gate_update_unit_assert.svh"

module clifford_tableau_gate_update_unit
  import ctgu_pkg::*;
#(
  parameter int unsigned MAX_QUBITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // op[2:0], qubit_a[7:3], qubit_b[12:8], zero pad
  input  logic        s_axis_tuser_i,  // table_sel[0]
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,  // row_z[31:0], row_x[63:32], row_sign[64], zero pad
  output logic        m_axis_tuser_o,  // status[0]
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // The tableau lives in one memory of 2*MAX_QUBITS rows. Stabilizer row i sits at address i,
  // destabilizer row i at MAX_QUBITS + i. Each entry holds {sign, x bits, z bits}.
  localparam int unsigned NumRows = 2 * MAX_QUBITS;
  localparam int unsigned AddrW   = $clog2(NumRows);
  localparam int unsigned RowW    = 2 * MAX_QUBITS + 1;
  localparam int unsigned OutW    = (MAX_QUBITS < RowFieldW) ? MAX_QUBITS : RowFieldW;
  localparam logic [AddrW-1:0] LastAddr   = AddrW'(NumRows - 1);
  localparam logic [AddrW-1:0] DestabBase = AddrW'(MAX_QUBITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_RD_ISSUE,
    ST_RD_CAPT,
    ST_DONE
  } state_e;

  // Applies one prepended gate to a single row, as a tableau row update.
  function automatic logic [RowW-1:0] gate_row(op_e op, logic [RowW-1:0] row,
                                               logic [MAX_QUBITS-1:0] ma,
                                               logic [MAX_QUBITS-1:0] mb);
    logic [MAX_QUBITS-1:0] z;
    logic [MAX_QUBITS-1:0] x;
    logic                  s;
    logic                  za;
    logic                  xa;
    logic                  zb;
    logic                  xb;
    z  = row[MAX_QUBITS-1:0];
    x  = row[2*MAX_QUBITS-1:MAX_QUBITS];
    s  = row[2*MAX_QUBITS];
    za = |(z & ma);
    xa = |(x & ma);
    zb = |(z & mb);
    xb = |(x & mb);
    case (op)
      OP_X: begin
        s = s ^ za;
      end
      OP_Z: begin
        s = s ^ xa;
      end
      OP_S: begin
        s = s ^ (za & xa);
        if (xa) begin
          z = z ^ ma;
        end
      end
      OP_H: begin
        s = s ^ (za & xa);
        if (za != xa) begin
          z = z ^ ma;
          x = x ^ ma;
        end
      end
      OP_CNOT: begin
        s = s ^ (za & xb);
        if (zb) begin
          z = z ^ ma;
        end
        if (xa) begin
          x = x ^ mb;
        end
      end
      default: begin
      end
    endcase
    return {s, x, z};
  endfunction

  // One-hot column mask of a qubit index.
  function automatic logic [MAX_QUBITS-1:0] qubit_mask(logic [QubitW-1:0] q);
    logic [MAX_QUBITS-1:0] m;
    for (int j = 0; j < MAX_QUBITS; j++) begin
      m[j] = (int'(q) == j);
    end
    return m;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Configuration register. A write of active_qubits also reloads the identity tableau.
  // ---------------------------------------------------------------------------------------
  logic [CfgW-1:0] active_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RegActiveQubits);
  assign prdata = (paddr[2] == RegActiveQubits) ? 32'(active_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ActiveQubitsReset;
    end else if (cfg_wr) begin
      active_q <= pwdata[CfgW-1:0];
    end
  end

  // The qubit count in effect: zero behaves as one, anything above the tableau size as the size.
  logic [CfgW-1:0] live_n;

  always_comb begin
    if (active_q == '0) begin
      live_n = CfgW'(1);
    end else if ({1'b0, active_q} > 7'(MAX_QUBITS)) begin
      live_n = CfgW'(MAX_QUBITS);
    end else begin
      live_n = active_q;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Input decode.
  // ---------------------------------------------------------------------------------------
  logic [OpW-1:0]    in_op;
  logic [QubitW-1:0] in_a;
  logic [QubitW-1:0] in_b;
  logic              in_sel;
  logic              accept;
  logic              a_bad;
  logic              b_bad;

  assign in_op  = s_axis_tdata_i[2:0];
  assign in_a   = s_axis_tdata_i[7:3];
  assign in_b   = s_axis_tdata_i[12:8];
  assign in_sel = s_axis_tuser_i;
  assign a_bad  = ({1'b0, in_a} >= live_n);
  assign b_bad  = ({1'b0, in_b} >= live_n);

  // A new transaction is taken whenever the sequencer is free, even while the previous result
  // still waits in the output register.
  state_e state_q;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // ---------------------------------------------------------------------------------------
  // Tableau memory with registered read, plus one valid bit per row. A row whose valid bit is
  // clear reads as its identity value, which lets reset and re-initialize just clear the bits.
  // ---------------------------------------------------------------------------------------
  logic [RowW-1:0]    mem_q [NumRows];
  logic [NumRows-1:0] valid_q;
  logic [AddrW-1:0]   cnt_q;
  logic [AddrW-1:0]   addr_q;
  logic [AddrW-1:0]   mem_raddr;
  logic [RowW-1:0]    mem_rd_q;
  logic [AddrW-1:0]   rd_addr_q;
  logic               row_vld_q;
  logic               pend_q;
  logic               mem_we;
  logic               clr_valid;
  logic [RowW-1:0]    ident_row;
  logic [RowW-1:0]    rd_row;
  logic [RowW-1:0]    wr_row;
  op_e                op_q;
  logic [MAX_QUBITS-1:0] mask_a_q;
  logic [MAX_QUBITS-1:0] mask_b_q;

  assign mem_raddr = (state_q == ST_SWEEP) ? cnt_q : addr_q;
  assign mem_we    = pend_q;
  assign clr_valid = cfg_wr || (accept && (in_op == OP_REINIT));

  always_ff @(posedge clk_i) begin
    mem_rd_q  <= mem_q[mem_raddr];
    row_vld_q <= valid_q[mem_raddr];
    rd_addr_q <= mem_raddr;
    if (mem_we) begin
      mem_q[rd_addr_q] <= wr_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      pend_q <= (state_q == ST_SWEEP);
      if (clr_valid) begin
        valid_q <= '0;
      end else if (mem_we) begin
        valid_q[rd_addr_q] <= 1'b1;
      end
    end
  end

  // Identity value of the row just read: Z_i for stabilizers, X_i for destabilizers, zero for
  // rows beyond the live qubit count.
  always_comb begin
    logic [AddrW-1:0]      idx;
    logic                  in_range;
    logic [MAX_QUBITS-1:0] oh;
    idx      = (rd_addr_q < DestabBase) ? rd_addr_q : AddrW'(rd_addr_q - DestabBase);
    in_range = (32'(idx) < 32'(live_n));
    for (int j = 0; j < MAX_QUBITS; j++) begin
      oh[j] = in_range && (int'(idx) == j);
    end
    if (rd_addr_q < DestabBase) begin
      ident_row = {1'b0, {MAX_QUBITS{1'b0}}, oh};
    end else begin
      ident_row = {1'b0, oh, {MAX_QUBITS{1'b0}}};
    end
  end

  assign rd_row = row_vld_q ? mem_rd_q : ident_row;
  assign wr_row = gate_row(op_q, rd_row, mask_a_q, mask_b_q);

  // ---------------------------------------------------------------------------------------
  // Sequencer and output register. A gate sweeps every row: the read of row k+1 overlaps the
  // write-back of row k, and the final drain state writes the last row.
  // ---------------------------------------------------------------------------------------
  logic                 res_status_q;
  logic [RowFieldW-1:0] res_z_q;
  logic [RowFieldW-1:0] res_x_q;
  logic                 res_sign_q;
  logic                 m_tvalid_q;
  logic                 m_status_q;
  logic [RowFieldW-1:0] m_z_q;
  logic [RowFieldW-1:0] m_x_q;
  logic                 m_sign_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      op_q         <= OP_X;
      mask_a_q     <= '0;
      mask_b_q     <= '0;
      addr_q       <= '0;
      cnt_q        <= '0;
      res_status_q <= StatusDone;
      res_z_q      <= '0;
      res_x_q      <= '0;
      res_sign_q   <= 1'b0;
      m_tvalid_q   <= 1'b0;
      m_status_q   <= StatusDone;
      m_z_q        <= '0;
      m_x_q        <= '0;
      m_sign_q     <= 1'b0;
    end else begin
      // A taken result empties the output register unless a finished one refills it below.
      if (m_tvalid_q && m_axis_tready_i && (state_q != ST_DONE)) begin
        m_tvalid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            op_q         <= op_e'(in_op);
            mask_a_q     <= qubit_mask(in_a);
            mask_b_q     <= qubit_mask(in_b);
            addr_q       <= in_sel ? AddrW'(DestabBase + AddrW'(in_a)) : AddrW'(in_a);
            cnt_q        <= '0;
            res_status_q <= StatusDone;
            res_z_q      <= '0;
            res_x_q      <= '0;
            res_sign_q   <= 1'b0;
            case (op_e'(in_op))
              OP_REINIT: begin
                state_q <= ST_DONE;
              end
              OP_READ: begin
                if (a_bad) begin
                  res_status_q <= StatusReject;
                  state_q      <= ST_DONE;
                end else begin
                  state_q <= ST_RD_ISSUE;
                end
              end
              OP_X, OP_Z, OP_S, OP_H: begin
                if (a_bad) begin
                  res_status_q <= StatusReject;
                  state_q      <= ST_DONE;
                end else begin
                  state_q <= ST_SWEEP;
                end
              end
              OP_CNOT: begin
                if (a_bad || b_bad || (in_a == in_b)) begin
                  res_status_q <= StatusReject;
                  state_q      <= ST_DONE;
                end else begin
                  state_q <= ST_SWEEP;
                end
              end
              default: begin
                res_status_q <= StatusReject;
                state_q      <= ST_DONE;
              end
            endcase
          end
        end
        ST_SWEEP: begin
          cnt_q <= AddrW'(cnt_q + 1'b1);
          if (cnt_q == LastAddr) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_DONE;
        end
        ST_RD_ISSUE: begin
          state_q <= ST_RD_CAPT;
        end
        ST_RD_CAPT: begin
          res_z_q    <= RowFieldW'(rd_row[OutW-1:0]);
          res_x_q    <= RowFieldW'(rd_row[MAX_QUBITS+OutW-1:MAX_QUBITS]);
          res_sign_q <= rd_row[2*MAX_QUBITS];
          state_q    <= ST_DONE;
        end
        ST_DONE: begin
          // The result moves to the output register as soon as it is empty or being emptied.
          if (!m_tvalid_q || m_axis_tready_i) begin
            m_tvalid_q <= 1'b1;
            m_status_q <= res_status_q;
            m_z_q      <= res_z_q;
            m_x_q      <= res_x_q;
            m_sign_q   <= res_sign_q;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = {7'd0, m_sign_q, m_x_q, m_z_q};
  assign m_axis_tuser_o  = m_status_q;

  // ---------------------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------------------
  `CTGU_ASSERT_NOW(a_write_in_sweep, mem_we, (state_q == ST_SWEEP) || (state_q == ST_DRAIN), "tableau written outside a gate sweep")
  `CTGU_ASSERT_NOW(a_write_trails_read, (state_q == ST_SWEEP) && pend_q, cnt_q == AddrW'(rd_addr_q + 1'b1), "write-back does not trail the read by one row")
  `CTGU_ASSERT_NEXT(a_result_from_done, !m_tvalid_q && (state_q != ST_DONE), !m_tvalid_q, "result appeared without a finished transaction")
  `CTGU_ASSERT_NOW(a_reject_zero_row, m_tvalid_q && (m_status_q == StatusReject), (m_z_q == '0) && (m_x_q == '0) && !m_sign_q, "rejected transaction carries row data")

endmodule
